@@ rtl/fsnp_pkg.sv @@
// fsnp_pkg: shared types and constants of the nearest-neighbor downscaler
// used by fsnp_ctrl, fsnp_dp and fit_scale_nearest_palette_top; no dependencies
package fsnp_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 3'd4;

	// output modes
	localparam logic [1:0] MODE_INDEX   = 2'd1;
	localparam logic [1:0] MODE_PALETTE = 2'd2;

	// item kinds
	localparam logic REQ_PALETTE = 1'b0;
	localparam logic REQ_PIXEL   = 1'b1;

	// reset values of the registers
	localparam logic [12:0] RST_SOURCE_WIDTH  = 13'd1;
	localparam logic [12:0] RST_SOURCE_HEIGHT = 13'd1;
	localparam logic [7:0]  RST_LIMIT_WIDTH   = 8'd249;
	localparam logic [8:0]  RST_LIMIT_HEIGHT  = 9'd384;

	// saturation of the destination size
	localparam logic [7:0] DEST_W_MAX = 8'd255;
	localparam logic [8:0] DEST_H_MAX = 9'd511;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVW_GO,
		ST_DIVW,
		ST_DIVH_GO,
		ST_DIVH,
		ST_MUL,
		ST_FIT,
		ST_EVAL
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take_pal;
		logic take_pix;
		logic div_start;
		logic div_sel;
		logic cap_rw;
		logic cap_rh;
		logic mul;
		logic fit;
		logic eval;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic frame_start;
		logic src_zero;
		logic div_busy;
		logic hit;
		logic out_block;
	} dp_status_t;

endpackage

@@ rtl/fit_scale_nearest_palette_top.sv @@
// fit_scale_nearest_palette_top: top level of the nearest-neighbor downscaler
// depends on fsnp_pkg, fsnp_ctrl, fsnp_dp, fsnp_div
//
// Usage:
//   input channel (in_valid/in_stall) carries palette writes (req_type 0) and
//   source pixels in raster order (req_type 1); output channel (out_valid/out_stall)
//   carries destination pixels with their column, row and a frame_end mark.
//   Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data, by the
//   user only while idle; the block does not enforce it. cfg_ready is always high.
// Item flow:
//   a palette write is taken while idle; a pixel is captured, then evaluated
//   while in_stall holds off the next item, and its result is shown in the
//   output register on the cycle after evaluation. The first pixel of a frame
//   also sizes the destination: two restoring divisions of SRC_W+8 steps each
//   (SRC_W = clog2(MAX_SOURCE_DIM+1)), a multiply and a fit step.
// Reset: counters and destination size clear, registers take reset values;
//   the palette holds garbage until written.
// Stall: a waiting result does not block the next item; evaluation of a pixel
//   that hits holds only while the output register is full and stalled.
module fit_scale_nearest_palette_top #(
	parameter int MAX_SOURCE_DIM  = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fsnp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsnp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [7:0]                      palette_slot,
	input  logic [15:0]                     palette_color,
	input  logic [15:0]                     pixel_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     out_pixel,
	output logic [7:0]                      out_column,
	output logic [8:0]                      out_row,
	output logic                            frame_end
);
	import fsnp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	fsnp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	fsnp_dp #(
		.MAX_SOURCE_DIM  (MAX_SOURCE_DIM),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.palette_slot  (palette_slot),
		.palette_color (palette_color),
		.pixel_value   (pixel_value),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_pixel     (out_pixel),
		.out_column    (out_column),
		.out_row       (out_row),
		.frame_end     (frame_end)
	);

endmodule

@@ rtl/fsnp_div.sv @@
// fsnp_div: restoring divider, one quotient bit per cycle
// stand-alone unit, no package use
module fsnp_div #(
	parameter int NW = 21,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          ge;

	// trial subtraction
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		ge      = shifted >= {1'b0, divisor};
		diff    = shifted - {1'b0, divisor};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/fsnp_ctrl.sv @@
// fsnp_ctrl: controller state machine of the downscaler
// depends on fsnp_pkg
module fsnp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                req_type,
	output logic                in_stall,
	input  fsnp_pkg::dp_status_t status,
	output fsnp_pkg::ctrl_cmd_t  cmd
);
	import fsnp_pkg::*;

	state_t state_q;
	state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == REQ_PIXEL && !status.src_zero) begin
					state_n = status.frame_start ? ST_DIVW_GO : ST_EVAL;
				end
			end
			ST_DIVW_GO: state_n = ST_DIVW;
			ST_DIVW: begin
				if (!status.div_busy) begin
					state_n = ST_DIVH_GO;
				end
			end
			ST_DIVH_GO: state_n = ST_DIVH;
			ST_DIVH: begin
				if (!status.div_busy) begin
					state_n = ST_MUL;
				end
			end
			ST_MUL: state_n = ST_FIT;
			ST_FIT: state_n = ST_EVAL;
			ST_EVAL: begin
				if (!(status.hit && status.out_block)) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		in_stall     = (state_q != ST_IDLE);
		cmd.take_pal = (state_q == ST_IDLE) && in_valid && req_type == REQ_PALETTE;
		cmd.take_pix = (state_q == ST_IDLE) && in_valid && req_type == REQ_PIXEL &&
			!status.src_zero;
		cmd.div_start = (state_q == ST_DIVW_GO) || (state_q == ST_DIVH_GO);
		cmd.div_sel   = (state_q == ST_DIVH_GO) || (state_q == ST_DIVH);
		cmd.cap_rw    = (state_q == ST_DIVW) && !status.div_busy;
		cmd.cap_rh    = (state_q == ST_DIVH) && !status.div_busy;
		cmd.mul       = (state_q == ST_MUL);
		cmd.fit       = (state_q == ST_FIT);
		cmd.eval      = (state_q == ST_EVAL) && !(status.hit && status.out_block);
	end

`ifndef SYNTHESIS
	a_cap_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_rw |-> $past(state_q) == ST_DIVW || $past(state_q) == ST_DIVW_GO)
		else $error("ratio captured outside a division");
	a_eval_after_fit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIT |=> state_q == ST_EVAL)
		else $error("fit not followed by evaluation");
	a_pix_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_pix |=> state_q != ST_IDLE)
		else $error("pixel taken without evaluation");
`endif

endmodule

@@ rtl/fsnp_dp.sv @@
// fsnp_dp: datapath of the downscaler: registers, sizing, counters, palette, output
// depends on fsnp_pkg and fsnp_div
module fsnp_dp #(
	parameter int MAX_SOURCE_DIM  = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [fsnp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsnp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                        palette_slot,
	input  logic [15:0]                       palette_color,
	input  logic [15:0]                       pixel_value,
	input  fsnp_pkg::ctrl_cmd_t               cmd,
	output fsnp_pkg::dp_status_t              status,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [15:0]                       out_pixel,
	output logic [7:0]                        out_column,
	output logic [8:0]                        out_row,
	output logic                              frame_end
);
	import fsnp_pkg::*;

	localparam int SRC_W = $clog2(MAX_SOURCE_DIM + 1);
	localparam int EW    = (SRC_W > CFG_DATA_W) ? SRC_W : CFG_DATA_W;
	localparam int CMPW  = (SRC_W > 9) ? SRC_W : 9;
	localparam int QW    = SRC_W + 8;
	localparam int PW    = QW + 9;
	localparam int AW    = SRC_W + 9;
	localparam int PAW   = $clog2(PALETTE_ENTRIES);

	// configuration registers
	logic [12:0] src_w_q;
	logic [12:0] src_h_q;
	logic [7:0]  lim_w_q;
	logic [8:0]  lim_h_q;
	logic [1:0]  mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SOURCE_WIDTH;
			src_h_q <= RST_SOURCE_HEIGHT;
			lim_w_q <= RST_LIMIT_WIDTH;
			lim_h_q <= RST_LIMIT_HEIGHT;
			mode_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_LIMIT_WIDTH:   lim_w_q <= cfg_data[7:0];
				REG_LIMIT_HEIGHT:  lim_h_q <= cfg_data[8:0];
				REG_OUTPUT_MODE:   mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// source size clamped to the largest supported dimension
	logic [EW-1:0]    sw_ext, sh_ext;
	logic [SRC_W-1:0] sw, sh;

	always_comb begin
		sw_ext = EW'(src_w_q);
		sh_ext = EW'(src_h_q);
		sw = (sw_ext > EW'(MAX_SOURCE_DIM)) ? SRC_W'(MAX_SOURCE_DIM) : SRC_W'(sw_ext);
		sh = (sh_ext > EW'(MAX_SOURCE_DIM)) ? SRC_W'(MAX_SOURCE_DIM) : SRC_W'(sh_ext);
	end

	// shared divider for the two aspect ratios
	logic [QW-1:0]    div_quo;
	logic             div_busy;
	logic [QW-1:0]    rw_q, rh_q;

	fsnp_div #(.NW(QW), .DW(SRC_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({(cmd.div_sel ? sh : sw), 8'd0}),
		.divisor  (cmd.div_sel ? sw : sh),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_rw) begin
			rw_q <= div_quo;
		end
		if (cmd.cap_rh) begin
			rh_q <= div_quo;
		end
	end

	// fit decision and scaled side
	logic          over_w, over_h, over, by_width;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] w_full, h_full;
	logic [7:0]    dw_n;
	logic [8:0]    dh_n;

	always_comb begin
		over_w   = CMPW'(sw) > CMPW'(lim_w_q);
		over_h   = CMPW'(sh) > CMPW'(lim_h_q);
		over     = over_w || over_h;
		by_width = (rw_q > rh_q) ? over_w : !over_h;
		if (!over) begin
			w_full = PW'(sw);
			h_full = PW'(sh);
		end else if (by_width) begin
			w_full = PW'(lim_w_q);
			h_full = prod_q >> 8;
		end else begin
			w_full = prod_q >> 8;
			h_full = PW'(lim_h_q);
		end
		dw_n = (w_full > PW'(DEST_W_MAX)) ? DEST_W_MAX : w_full[7:0];
		dh_n = (h_full > PW'(DEST_H_MAX)) ? DEST_H_MAX : h_full[8:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= by_width ? PW'(lim_w_q) * PW'(rh_q) : PW'(lim_h_q) * PW'(rw_q);
		end
	end

	// frame counters and accumulators
	logic [7:0]       dest_w_q, dst_col_q;
	logic [8:0]       dest_h_q, dst_row_q;
	logic [SRC_W-1:0] src_col_q, src_row_q;
	logic [AW-1:0]    col_acc_q, row_acc_q, col_lim_q, row_lim_q;
	logic             row_hit, col_hit, hit, col_last, row_last, fend;

	always_comb begin
		row_hit  = (dst_row_q < dest_h_q) && (row_acc_q < row_lim_q);
		col_hit  = (dst_col_q < dest_w_q) && (col_acc_q < col_lim_q);
		hit      = row_hit && col_hit;
		col_last = ((SRC_W + 1)'(src_col_q) + 1'b1) >= (SRC_W + 1)'(sw);
		row_last = ((SRC_W + 1)'(src_row_q) + 1'b1) >= (SRC_W + 1)'(sh);
		fend     = (9'(dst_col_q) + 1'b1 == 9'(dest_w_q)) &&
			(10'(dst_row_q) + 1'b1 == 10'(dest_h_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_w_q  <= '0;
			dest_h_q  <= '0;
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			col_acc_q <= '0;
			row_acc_q <= '0;
			col_lim_q <= '0;
			row_lim_q <= '0;
		end else if (cmd.fit) begin
			dest_w_q  <= dw_n;
			dest_h_q  <= dh_n;
			dst_col_q <= '0;
			dst_row_q <= '0;
			col_acc_q <= '0;
			row_acc_q <= '0;
			col_lim_q <= AW'(dw_n);
			row_lim_q <= AW'(dh_n);
		end else if (cmd.eval) begin
			if (col_last) begin
				src_col_q <= '0;
				dst_col_q <= '0;
				col_acc_q <= '0;
				col_lim_q <= AW'(dest_w_q);
				if (row_hit) begin
					dst_row_q <= dst_row_q + 1'b1;
					row_acc_q <= row_acc_q + AW'(sh);
				end
				if (row_last) begin
					src_row_q <= '0;
					row_lim_q <= AW'(dest_h_q);
				end else begin
					src_row_q <= src_row_q + 1'b1;
					row_lim_q <= row_lim_q + AW'(dest_h_q);
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
				col_lim_q <= col_lim_q + AW'(dest_w_q);
				if (col_hit) begin
					dst_col_q <= dst_col_q + 1'b1;
					col_acc_q <= col_acc_q + AW'(sw);
				end
			end
		end
	end

	// palette memory and pixel capture
	logic [15:0] pal_mem [PALETTE_ENTRIES];
	logic [15:0] pal_rd_q;
	logic [15:0] pix_q;
	logic        oob_q;

	always_ff @(posedge clk) begin
		if (cmd.take_pal && (9'(palette_slot) < 9'(PALETTE_ENTRIES))) begin
			pal_mem[palette_slot[PAW-1:0]] <= palette_color;
		end
		if (cmd.take_pix) begin
			pal_rd_q <= pal_mem[pixel_value[PAW-1:0]];
			oob_q    <= 9'(pixel_value[7:0]) >= 9'(PALETTE_ENTRIES);
			pix_q    <= pixel_value;
		end
	end

	// output value per mode
	logic [15:0] pix_sel;

	always_comb begin
		if (mode_q == MODE_INDEX) begin
			pix_sel = {8'd0, pix_q[7:0]};
		end else if (mode_q == MODE_PALETTE) begin
			pix_sel = oob_q ? 16'd0 : pal_rd_q;
		end else begin
			pix_sel = pix_q;
		end
	end

	// output register
	logic out_valid_q;
	logic load;

	assign load = cmd.eval && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pixel  <= pix_sel;
			out_column <= dst_col_q;
			out_row    <= dst_row_q;
			frame_end  <= fend;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.frame_start = (src_col_q == '0) && (src_row_q == '0);
		status.src_zero    = (sw == '0) || (sh == '0);
		status.div_busy    = div_busy;
		status.hit         = hit;
		status.out_block   = out_valid_q && out_stall;
	end

`ifndef SYNTHESIS
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dst_col_q <= dest_w_q)
		else $error("destination column beyond width");
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dst_row_q <= dest_h_q)
		else $error("destination row beyond height");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");
`endif

endmodule
